/* hdl/dtsm_pkg.sv */
// ----------------------------------------------------------------------------
// dtsm_pkg
// Shared constants of the dwell-toggle stroke mapper.
// ----------------------------------------------------------------------------
`default_nettype none
package dtsm_pkg;
   localparam int COEF_BITS    = 48;
   localparam int NUM_COEFS    = 8;
   localparam int CSR_IDX_BITS = 3;
   localparam int OUT_BITS     = 16;
   localparam int STILL_RANGE  = 3;
   localparam int TOGGLE_COUNT = 14;

   localparam logic [1:0] MODE_TRACK   = 2'd0;
   localparam logic [1:0] MODE_LOST    = 2'd1;
   localparam logic [1:0] MODE_RESTART = 2'd2;
   localparam logic [1:0] MODE_NONE    = 2'd3;

   localparam logic [CSR_IDX_BITS-1:0] IDX_XX = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] IDX_XY = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] IDX_XO = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] IDX_YX = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] IDX_YY = 3'd4;
   localparam logic [CSR_IDX_BITS-1:0] IDX_YO = 3'd5;
   localparam logic [CSR_IDX_BITS-1:0] IDX_WX = 3'd6;
   localparam logic [CSR_IDX_BITS-1:0] IDX_WY = 3'd7;
endpackage
`default_nettype wire

/* hdl/dtsm_div.sv */
// ----------------------------------------------------------------------------
// dtsm_div
// Bit-serial signed divider: one quotient bit per cycle, truncating, with
// 16-bit saturation and zero-denominator flag.
// ----------------------------------------------------------------------------
`default_nettype none
module dtsm_div #(
   parameter int W = 80
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   input  wire logic signed [W-1:0]    num,
   input  wire logic signed [W-1:0]    den,
   output logic                        busy,
   output logic                        done,
   output logic signed [dtsm_pkg::OUT_BITS-1:0] quot,
   output logic                        err
);
   localparam int CW = $clog2(W+1);
   logic [W-1:0]  n_ff, n_in, d_ff, d_in, q_ff, q_in;
   logic [W:0]    r_ff, r_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          neg_ff, neg_in, busy_ff, busy_in, done_ff, done_in, z_ff, z_in;
   logic [W:0]    shifted, diff;
   logic          big;

   always_comb begin
      n_in = n_ff; d_in = d_ff; q_in = q_ff; r_in = r_ff; cnt_in = cnt_ff;
      neg_in = neg_ff; busy_in = busy_ff; done_in = 1'b0; z_in = z_ff;
      shifted = {r_ff[W-1:0], n_ff[W-1]};
      diff = shifted - {1'b0, d_ff};
      if (start) begin
         n_in = num[W-1] ? W'(-num) : num;
         d_in = den[W-1] ? W'(-den) : den;
         neg_in = num[W-1] ^ den[W-1];
         z_in = (den == '0);
         r_in = '0; q_in = '0;
         cnt_in = CW'(W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         n_in = {n_ff[W-2:0], 1'b0};
         if (!diff[W]) begin
            r_in = diff; q_in = {q_ff[W-2:0], 1'b1};
         end else begin
            r_in = shifted; q_in = {q_ff[W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      n_ff <= n_in; d_ff <= d_in; q_ff <= q_in; r_ff <= r_in; neg_ff <= neg_in;
      z_ff <= z_in;
      if (reset) begin
         cnt_ff <= '0; busy_ff <= 1'b0; done_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in; busy_ff <= busy_in; done_ff <= done_in;
      end
   end

   always_comb begin
      big = neg_ff ? (q_ff > W'(32768)) : (q_ff > W'(32767));
      if (z_ff) begin
         quot = '0; err = 1'b1;
      end else if (big) begin
         quot = neg_ff ? 16'sh8000 : 16'sh7fff; err = 1'b1;
      end else begin
         quot = neg_ff ? 16'(-q_ff[15:0]) : 16'(q_ff[15:0]); err = 1'b0;
      end
   end
   assign busy = busy_ff;
   assign done = done_ff;
endmodule
`default_nettype wire

/* hdl/dtsm_mac.sv */
// ----------------------------------------------------------------------------
// dtsm_mac
// Serial multiply-accumulate: coef*x + coef*y + offset, one bit of the
// coordinate per cycle, giving a numerator or denominator.
// ----------------------------------------------------------------------------
`default_nettype none
module dtsm_mac #(
   parameter int CB = 11,
   parameter int W  = 80
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   input  wire logic signed [dtsm_pkg::COEF_BITS-1:0] ga,
   input  wire logic signed [dtsm_pkg::COEF_BITS-1:0] gb,
   input  wire logic signed [W-1:0] base,
   input  wire logic [CB-1:0]       x,
   input  wire logic [CB-1:0]       y,
   output logic                     done,
   output logic signed [W-1:0]      acc
);
   localparam int CW = $clog2(CB+1);
   logic signed [W-1:0] acc_ff, acc_in, a_ff, a_in, b_ff, b_in;
   logic [CB-1:0]       x_ff, x_in, y_ff, y_in;
   logic [CW-1:0]       cnt_ff, cnt_in;
   logic                busy_ff, busy_in, done_ff, done_in;

   always_comb begin
      acc_in = acc_ff; a_in = a_ff; b_in = b_ff; x_in = x_ff; y_in = y_ff;
      cnt_in = cnt_ff; busy_in = busy_ff; done_in = 1'b0;
      if (start) begin
         acc_in = base;
         a_in = W'(ga); b_in = W'(gb);
         x_in = x; y_in = y; cnt_in = CW'(CB); busy_in = 1'b1;
      end else if (busy_ff) begin
         acc_in = acc_ff + (x_ff[0] ? a_ff : '0) + (y_ff[0] ? b_ff : '0);
         a_in = a_ff <<< 1; b_in = b_ff <<< 1;
         x_in = x_ff >> 1; y_in = y_ff >> 1;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in; a_ff <= a_in; b_ff <= b_in; x_ff <= x_in; y_ff <= y_in;
      if (reset) begin
         cnt_ff <= '0; busy_ff <= 1'b0; done_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in; busy_ff <= busy_in; done_ff <= done_in;
      end
   end
   assign done = done_ff;
   assign acc = acc_ff;
endmodule
`default_nettype wire

/* hdl/dwell_toggle_stroke_mapper_core.sv */
// ----------------------------------------------------------------------------
// dwell_toggle_stroke_mapper_core
// Dwell-toggle pen tracker with homography-mapped stroke segments.
// ----------------------------------------------------------------------------
// Usage: one request per video frame on req_ (tdata = mode, center_x,
// center_y). Each request gives exactly one response on rsp_. Tracking state
// updates in the accept cycle. When a segment is produced, four mapped
// coordinates are computed one after another: each passes through a setup
// state, the serial multiply-accumulate pair and the bit-serial divider. A
// segment response is valid once the fourth coordinate is divided; a frame
// without a segment answers in the next cycle. One request is in flight at a
// time; req_tready is low until the response is taken. The response is held
// in rsp_tdata while rsp_tready is low. Coefficients are to be written on
// csr_ by the user only while idle; the block itself does not enforce this.
// Reset loads the identity homography and clears all tracking state.
// ----------------------------------------------------------------------------
`default_nettype none
module dwell_toggle_stroke_mapper_core #(
   parameter int COORD_BITS = 11,
   parameter int FRAC_BITS  = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // [1:0] mode, [COORD_BITS+1:2] center_x, then center_y, zero pad
   input  wire logic [((2+2*COORD_BITS+7)/8)*8-1:0] req_tdata,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [0] pen_down [1] toggled [2] segment_valid [18:3] start_x [34:19] start_y
   // [50:35] end_x [66:51] end_y [67] map_error, zero pad
   output logic [71:0]      rsp_tdata,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [dtsm_pkg::CSR_IDX_BITS-1:0] csr_index,
   input  wire logic [dtsm_pkg::COEF_BITS-1:0]    csr_data
);
   localparam int CB = dtsm_pkg::COEF_BITS;
   localparam int W  = CB + COORD_BITS + 2 + ((FRAC_BITS > CB) ? FRAC_BITS - CB : 0) + 2;

   typedef enum logic [2:0] {S_IDLE, S_MAC, S_DIV, S_NEXT, S_OUT} st_type;
   st_type st_ff;

   logic signed [CB-1:0] coef_ff [dtsm_pkg::NUM_COEFS];
   logic [COORD_BITS-1:0] hold_x_ff, hold_y_ff, last_x_ff, last_y_ff;
   logic [7:0] still_ff;
   logic writing_ff, has_prev_ff;
   logic [COORD_BITS-1:0] px_ff, py_ff, nx_ff, ny_ff;
   logic [1:0] k_ff;
   logic signed [15:0] res_ff [4];
   logic err_ff, valid_ff, tog_ff;

   logic [1:0] mode;
   logic [COORD_BITS-1:0] cx, cy;
   assign mode = req_tdata[1:0];
   assign cx   = req_tdata[2 +: COORD_BITS];
   assign cy   = req_tdata[2+COORD_BITS +: COORD_BITS];

   logic req_fire, rsp_fire;
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_fire   = rsp_tvalid && rsp_tready;
   assign req_tready = (st_ff == S_IDLE);
   assign rsp_tvalid = (st_ff == S_OUT);
   assign csr_ready  = 1'b1;

   // tracking next state
   logic [COORD_BITS-1:0] hx, hy, pxn, pyn, nxn, nyn;
   logic signed [COORD_BITS:0] dx, dy;
   logic [7:0] sc;
   logic wr;
   always_comb begin
      hx = (still_ff == 8'd0) ? cx : hold_x_ff;
      hy = (still_ff == 8'd0) ? cy : hold_y_ff;
      dx = $signed({1'b0, hx}) - $signed({1'b0, cx});
      dy = $signed({1'b0, hy}) - $signed({1'b0, cy});
      if (dx > -(COORD_BITS+1)'(dtsm_pkg::STILL_RANGE) && dx < (COORD_BITS+1)'(dtsm_pkg::STILL_RANGE)
          && dy > -(COORD_BITS+1)'(dtsm_pkg::STILL_RANGE)
          && dy < (COORD_BITS+1)'(dtsm_pkg::STILL_RANGE))
         sc = (still_ff == 8'd255) ? still_ff : still_ff + 8'd1;
      else
         sc = 8'd0;
      wr = (sc == 8'(dtsm_pkg::TOGGLE_COUNT)) ? !writing_ff : writing_ff;
      pxn = (has_prev_ff && !(sc == 8'(dtsm_pkg::TOGGLE_COUNT) && writing_ff)) ? last_x_ff : cx;
      pyn = (has_prev_ff && !(sc == 8'(dtsm_pkg::TOGGLE_COUNT) && writing_ff)) ? last_y_ff : cy;
      nxn = COORD_BITS'(({1'b0, cx} + {1'b0, pxn}) >> 1);
      nyn = COORD_BITS'(({1'b0, cy} + {1'b0, pyn}) >> 1);
   end

   // arithmetic units
   logic mac_start, num_done, den_done, div_busy, div_done, div_err;
   logic signed [W-1:0] num, den;
   logic signed [15:0] quot;
   logic [COORD_BITS-1:0] ux, uy;
   logic signed [CB-1:0] ga, gb;
   logic signed [W-1:0] gbase, one_base;
   assign mac_start = (st_ff == S_NEXT);
   assign ux = k_ff[1] ? nx_ff : px_ff;
   assign uy = k_ff[1] ? ny_ff : py_ff;
   assign ga = k_ff[0] ? coef_ff[dtsm_pkg::IDX_YX] : coef_ff[dtsm_pkg::IDX_XX];
   assign gb = k_ff[0] ? coef_ff[dtsm_pkg::IDX_YY] : coef_ff[dtsm_pkg::IDX_XY];
   assign gbase = W'(k_ff[0] ? coef_ff[dtsm_pkg::IDX_YO] : coef_ff[dtsm_pkg::IDX_XO]);
   assign one_base = W'(1) <<< FRAC_BITS;

   dtsm_mac #(.CB(COORD_BITS), .W(W)) u_num (
      .clock, .reset, .start(mac_start), .ga(ga), .gb(gb), .base(gbase),
      .x(ux), .y(uy), .done(num_done), .acc(num));
   dtsm_mac #(.CB(COORD_BITS), .W(W)) u_den (
      .clock, .reset, .start(mac_start), .ga(coef_ff[dtsm_pkg::IDX_WX]),
      .gb(coef_ff[dtsm_pkg::IDX_WY]), .base(one_base),
      .x(ux), .y(uy), .done(den_done), .acc(den));
   dtsm_div #(.W(W)) u_div (
      .clock, .reset, .start(num_done), .num(num), .den(den),
      .busy(div_busy), .done(div_done), .quot(quot), .err(div_err));

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE;
         for (int i = 0; i < dtsm_pkg::NUM_COEFS; i++)
            coef_ff[i] <= (i == int'(dtsm_pkg::IDX_XX) || i == int'(dtsm_pkg::IDX_YY)) ?
                          CB'(64'd1 << 32) : CB'(0);
         hold_x_ff <= '0; hold_y_ff <= '0; last_x_ff <= '0; last_y_ff <= '0;
         still_ff <= '0; writing_ff <= 1'b0; has_prev_ff <= 1'b0;
         k_ff <= '0; err_ff <= 1'b0; valid_ff <= 1'b0; tog_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) coef_ff[csr_index] <= csr_data;
         unique case (st_ff)
            S_IDLE: if (req_fire) begin
               k_ff <= '0; err_ff <= 1'b0;
               for (int i = 0; i < 4; i++) res_ff[i] <= '0;
               case (mode)
                  dtsm_pkg::MODE_TRACK: begin
                     hold_x_ff <= hx; hold_y_ff <= hy; still_ff <= sc;
                     writing_ff <= wr; tog_ff <= wr ^ writing_ff;
                     valid_ff <= wr;
                     st_ff <= wr ? S_NEXT : S_OUT;
                     if (!wr) begin
                        if (sc == 8'(dtsm_pkg::TOGGLE_COUNT)) has_prev_ff <= 1'b0;
                     end else begin
                        px_ff <= pxn; py_ff <= pyn; nx_ff <= nxn; ny_ff <= nyn;
                        last_x_ff <= nxn; last_y_ff <= nyn; has_prev_ff <= 1'b1;
                     end
                  end
                  dtsm_pkg::MODE_LOST: begin
                     writing_ff <= 1'b0; tog_ff <= writing_ff;
                     valid_ff <= 1'b0; st_ff <= S_OUT;
                  end
                  dtsm_pkg::MODE_RESTART: begin
                     hold_x_ff <= '0; hold_y_ff <= '0; last_x_ff <= '0;
                     last_y_ff <= '0; has_prev_ff <= 1'b0;
                     writing_ff <= 1'b0; tog_ff <= writing_ff;
                     valid_ff <= 1'b0; st_ff <= S_OUT;
                  end
                  default: begin
                     tog_ff <= 1'b0; valid_ff <= 1'b0; st_ff <= S_OUT;
                  end
               endcase
            end
            S_NEXT: st_ff <= S_MAC;
            S_MAC:  if (num_done) st_ff <= S_DIV;
            S_DIV:  if (div_done) begin
               res_ff[k_ff] <= quot;
               err_ff <= err_ff | div_err;
               k_ff <= k_ff + 2'd1;
               st_ff <= (k_ff == 2'd3) ? S_OUT : S_NEXT;
            end
            S_OUT: if (rsp_fire) st_ff <= S_IDLE;
            default: st_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_tdata = {4'd0, err_ff, res_ff[3], res_ff[2], res_ff[1], res_ff[0],
                       valid_ff, tog_ff, writing_ff};

   a_one_inflight: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_tready) else $error("request taken while busy");
   a_div_in_div: assert property (@(posedge clock) disable iff (reset)
      div_busy |-> st_ff == S_DIV) else $error("divider runs outside divide");
   a_mac_den: assert property (@(posedge clock) disable iff (reset)
      num_done == den_done) else $error("mac units out of step");
endmodule
`default_nettype wire
